// ----- sv/ptr_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ptr_pkg
// Shared types and constants for the paper tape reader controller.
// ---------------------------------------------------------------------------
package ptr_pkg;

	localparam int WORD_W  = 18;
	localparam int FRAME_W = 8;
	localparam int SHIFT_W = 5;

	// item kinds
	localparam logic [1:0] FUNC_CMD      = 2'd0;
	localparam logic [1:0] FUNC_FRAME    = 2'd1;
	localparam logic [1:0] FUNC_TAPE_END = 2'd2;
	localparam logic [1:0] FUNC_NOP      = 2'd3;

	// command bit positions
	localparam int PULSE_SKIP_BIT  = 0;
	localparam int PULSE_READ_BIT  = 1;
	localparam int PULSE_START_BIT = 2;
	localparam int PULSE_BIN_BIT   = 5;

	// frame bit that marks a binary frame
	localparam int BIN_MARK_BIT = 7;
	localparam int SIX_W        = 6;

	localparam logic [SHIFT_W-1:0] BIN_BITS  = 5'd18;
	localparam logic [SHIFT_W-1:0] SIX_STEP  = 5'd6;

	// register indexes
	localparam logic REG_TAPE_LOADED = 1'b0;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         pulse;
		logic [WORD_W-1:0]  acc_in;
		logic [FRAME_W-1:0] frame;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] acc_out;
		logic              skip;
		logic              frame_taken;
		logic              done_out;
		logic              error_out;
		logic              busy_out;
	} out_word_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word_buffer;
		logic [SHIFT_W-1:0] shift_left;
		logic               done_flag;
		logic               error_flag;
		logic               reading;
	} ptr_state_t;

endpackage
`default_nettype wire

// ----- sv/paper_tape_reader_controller.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// paper_tape_reader_controller
// Paper tape reader controller: commands, tape frames and tape-end events.
// ---------------------------------------------------------------------------
// One word is accepted every clock cycle while the result side does not stall,
// and each gives exactly one result word: the
// word is captured in an input register, the controller state is updated by
// a single pass of logic on that word, and the result is held in an
// output register. The rate is set by that state update loop. The
// tape_loaded register sits at byte address 0 of the APB-style port; writing
// it also sets the error flag when the tape is removed and clears it when a
// tape is mounted. After reset no tape is loaded, so error reads as set.
module paper_tape_reader_controller (
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               item_valid,
	output logic               item_ready,
	input  ptr_pkg::in_word_t  item,
	// result words
	output logic               result_valid,
	input  logic               result_ready,
	output ptr_pkg::out_word_t result,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ptr_pkg::*;

	// input register
	logic       valid_s1;
	in_word_t   item_s1;
	logic       adv_s1;

	// controller state and the mounted-tape register
	ptr_state_t state_q;
	ptr_state_t state_nxt;
	ptr_state_t state_upd;
	logic       tape_loaded_q;

	// output register
	logic       res_valid_q;
	out_word_t  res_q;
	out_word_t  res_nxt;

	logic       cfg_wr;

	// the input stage moves on whenever the output register is free or emptying
	assign adv_s1     = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == REG_TAPE_LOADED);

	ptr_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.tape_loaded (tape_loaded_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// control: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// next state: the word in the input stage, then a tape change on the error flag
	always_comb begin
		state_upd = adv_s1 ? state_nxt : state_q;
		if (cfg_wr) begin
			state_upd.error_flag = !pwdata[0];
		end
	end

	// controller state; a tape change rewrites the error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '{word_buffer: '0, shift_left: '0, done_flag: 1'b0,
				error_flag: 1'b1, reading: 1'b0};
			tape_loaded_q <= 1'b0;
		end else begin
			state_q <= state_upd;
			if (cfg_wr) begin
				tape_loaded_q <= pwdata[0];
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// register read back; only one register in the map
	assign prdata = (paddr[2] == REG_TAPE_LOADED) ? {31'b0, tape_loaded_q} : '0;
	assign pready = 1'b1;

endmodule
`default_nettype wire

// ----- sv/ptr_step.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ptr_step
// Next-state and result logic for one word: command, frame or tape end.
// ---------------------------------------------------------------------------
module ptr_step (
	input  ptr_pkg::ptr_state_t cur,
	input  ptr_pkg::in_word_t   item,
	input  logic                tape_loaded,
	output ptr_pkg::ptr_state_t nxt,
	output ptr_pkg::out_word_t  res
);
	import ptr_pkg::*;

	logic [WORD_W-1:0]       acc;
	logic [SHIFT_W-1:0]      shift;
	logic [WORD_W+SIX_W-1:0] six_wide;

	always_comb begin
		nxt      = cur;
		res      = '0;
		acc      = item.acc_in;
		shift    = cur.shift_left;
		six_wide = '0;
		case (item.func)
			FUNC_CMD: begin
				// skip looks at done before the command
				res.skip = item.pulse[PULSE_SKIP_BIT] & cur.done_flag;
				if (item.pulse[PULSE_READ_BIT]) begin
					nxt.done_flag = 1'b0;
					acc           = acc | cur.word_buffer;
				end
				if (item.pulse[PULSE_START_BIT]) begin
					nxt.shift_left  = item.pulse[PULSE_BIN_BIT] ? BIN_BITS : '0;
					nxt.done_flag   = 1'b0;
					nxt.word_buffer = '0;
					nxt.reading     = 1'b1;
				end
				res.acc_out = acc;
			end
			FUNC_FRAME: begin
				if (cur.reading) begin
					if (!tape_loaded) begin
						nxt.error_flag = 1'b1;
						nxt.done_flag  = 1'b1;
						nxt.reading    = 1'b0;
					end else begin
						res.frame_taken = 1'b1;
						if (shift == '0) begin
							nxt.word_buffer = {{(WORD_W-FRAME_W){1'b0}}, item.frame};
						end else if (item.frame[BIN_MARK_BIT]) begin
							shift    = (shift >= SIX_STEP) ? shift - SIX_STEP : '0;
							six_wide = {{WORD_W{1'b0}}, item.frame[SIX_W-1:0]} << shift;
							nxt.word_buffer = cur.word_buffer | six_wide[WORD_W-1:0];
						end
						nxt.shift_left = shift;
						if (shift == '0) begin
							nxt.done_flag = 1'b1;
							nxt.reading   = 1'b0;
						end
					end
				end
			end
			FUNC_TAPE_END: begin
				if (cur.reading) begin
					nxt.error_flag = 1'b1;
					nxt.done_flag  = 1'b1;
					nxt.reading    = 1'b0;
				end
			end
			default: ;
		endcase
		res.done_out  = nxt.done_flag;
		res.error_out = nxt.error_flag;
		res.busy_out  = nxt.reading;
	end

endmodule
`default_nettype wire

// ----- sv/ptr_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ptr_checker
// Port-level checks for the paper tape reader controller.
// ---------------------------------------------------------------------------
module ptr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input ptr_pkg::out_word_t result
);
	import ptr_pkg::*;

	// a read in progress never shows done at the same time
	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.busy_out && result.done_out))
		else $error("busy and done both set");

	// a consumed frame leaves the read either running or finished
	a_taken_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_taken) |-> (result.busy_out || result.done_out))
		else $error("frame taken with read neither busy nor done");

	// skip can only come with a command, which returns no frame
	a_skip_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.skip) |-> !result.frame_taken)
		else $error("skip and frame taken in one word");

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result word changed");

endmodule

bind paper_tape_reader_controller ptr_checker u_ptr_checker (.*);
`default_nettype wire

// ----- verif/tb_paper_tape_reader_controller.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_paper_tape_reader_controller
// Self-checking bench for the paper tape reader controller.
// ---------------------------------------------------------------------------
// A short directed run covers the edge cases first: a frame or tape end with
// no read active, a missing tape, alphanumeric and binary reads, an unmarked
// binary frame, tape end in mid-read, a restart and the no-operation item.
// Random phases follow under both tape settings. They are mostly complete
// read sequences with random content, mixed with noise and with sequences
// that are broken off. A scoreboard predicts every result word and checks
// the results in order. The sender works in bursts and the receiver stalls
// on patterns of its own.
module tb_paper_tape_reader_controller;
	import ptr_pkg::*;

	// cycles with no handshake before the run is declared hung
	localparam int STALL_LIMIT = 1000;
	localparam int ITEMS_PER_PHASE = 120;

	// ------------------------------------------------------------------
	// scoreboard: own copy of the controller state, queue of results due
	// ------------------------------------------------------------------
	class reader_scoreboard;
		ptr_state_t ctl;
		bit         tape_in;
		out_word_t  results_due[$];
		int         mismatches = 0;

		function void reset_state();
			ctl = '0;
			tape_in = 1'b0;
			ctl.error_flag = 1'b1;
			results_due.delete();
		endfunction

		// mounting a tape clears error, removing it sets error
		function void mount_tape(bit loaded);
			tape_in = loaded;
			ctl.error_flag = !loaded;
		endfunction

		function void abort_read();
			ctl.error_flag = 1'b1;
			ctl.done_flag = 1'b1;
			ctl.reading = 1'b0;
		endfunction

		function out_word_t reader_result(in_word_t w);
			out_word_t          r;
			logic [WORD_W-1:0]  acc;
			logic [WORD_W-1:0]  six;
			r = '0;
			acc = w.acc_in;
			case (w.func)
				FUNC_CMD: begin
					// skip sees done as it was before this command
					r.skip = w.pulse[PULSE_SKIP_BIT] & ctl.done_flag;
					if (w.pulse[PULSE_READ_BIT]) begin
						ctl.done_flag = 1'b0;
						acc = acc | ctl.word_buffer;
					end
					if (w.pulse[PULSE_START_BIT]) begin
						ctl.shift_left = w.pulse[PULSE_BIN_BIT] ? BIN_BITS : '0;
						ctl.done_flag = 1'b0;
						ctl.word_buffer = '0;
						ctl.reading = 1'b1;
					end
					r.acc_out = acc;
				end
				FUNC_FRAME: begin
					if (ctl.reading) begin
						if (!tape_in) begin
							abort_read();
						end else begin
							r.frame_taken = 1'b1;
							if (ctl.shift_left == '0) begin
								ctl.word_buffer = WORD_W'(w.frame);
							end else if (w.frame[BIN_MARK_BIT]) begin
								// high six bits land first
								ctl.shift_left = (ctl.shift_left >= SIX_STEP) ?
									ctl.shift_left - SIX_STEP : '0;
								six = WORD_W'(w.frame[SIX_W-1:0]);
								ctl.word_buffer = ctl.word_buffer | (six << ctl.shift_left);
							end
							if (ctl.shift_left == '0) begin
								ctl.done_flag = 1'b1;
								ctl.reading = 1'b0;
							end
						end
					end
				end
				FUNC_TAPE_END: begin
					if (ctl.reading)
						abort_read();
				end
				default: ;
			endcase
			r.done_out = ctl.done_flag;
			r.error_out = ctl.error_flag;
			r.busy_out = ctl.reading;
			return r;
		endfunction

		function void note_word(in_word_t w);
			results_due.push_back(reader_result(w));
		endfunction

		function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t: %s expected %h got %h", $time, field, want, got);
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t: result word %h expected none", $time, got);
				return;
			end
			want = results_due.pop_front();
			compare("acc_out", want.acc_out, got.acc_out);
			compare("skip", WORD_W'(want.skip), WORD_W'(got.skip));
			compare("frame_taken", WORD_W'(want.frame_taken), WORD_W'(got.frame_taken));
			compare("done_out", WORD_W'(want.done_out), WORD_W'(got.done_out));
			compare("error_out", WORD_W'(want.error_out), WORD_W'(got.error_out));
			compare("busy_out", WORD_W'(want.busy_out), WORD_W'(got.busy_out));
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction
	endclass

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG_STALL} rx_pattern_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	in_word_t    item;
	logic        result_valid;
	logic        result_ready;
	out_word_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	reader_scoreboard sb = new;

	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit sender_gaps = 1'b0;

	paper_tape_reader_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// results are checked in order at the edge where they are taken
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_word(result);
	end

	// watchdog: any handshake on either channel or the config port resets it
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: switches between stall patterns, picked at random
	initial begin
		rx_pattern_t rx_mode;
		int          mode_left;
		int          stall_left;
		int          tick;
		result_ready <= 1'b0;
		rx_mode = RX_OPEN;
		mode_left = 0;
		stall_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (mode_left == 0) begin
				rx_mode = rx_pattern_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN: result_ready <= 1'b1;
				RX_COIN: result_ready <= 1'($urandom);
				RX_PERIODIC: result_ready <= (tick % 3 != 0);
				default: begin
					if (stall_left == 0 && $urandom_range(0, 15) == 0)
						stall_left = $urandom_range(5, 30);
					if (stall_left > 0) begin
						stall_left--;
						result_ready <= 1'b0;
					end else begin
						result_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	function automatic in_word_t make_word(logic [1:0] f, logic [5:0] p,
			logic [WORD_W-1:0] a, logic [FRAME_W-1:0] fr);
		in_word_t w;
		w.func = f;
		w.pulse = p;
		w.acc_in = a;
		w.frame = fr;
		return w;
	endfunction

	// one word through the input handshake, with burst gaps when enabled
	task automatic send_word(input in_word_t w);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sb.note_word(w);
		items_sent++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_tape(input bit loaded);
		apb_write(3'(4 * REG_TAPE_LOADED), {31'b0, loaded});
		sb.mount_tape(loaded);
	endtask

	// every result in, then a wait for the two-stage pipe to settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_cmd(input logic [5:0] p, input logic [WORD_W-1:0] a);
		send_word(make_word(FUNC_CMD, p, a, FRAME_W'($urandom)));
	endtask

	task automatic send_frame(input logic [FRAME_W-1:0] fr);
		send_word(make_word(FUNC_FRAME, 6'($urandom), WORD_W'($urandom), fr));
	endtask

	task automatic send_tape_end();
		send_word(make_word(FUNC_TAPE_END, 6'($urandom), WORD_W'($urandom),
			FRAME_W'($urandom)));
	endtask

	// skip poll that never starts a read
	task automatic send_poll();
		logic [5:0] p;
		p = 6'($urandom);
		p[PULSE_START_BIT] = 1'b0;
		p[PULSE_SKIP_BIT] = 1'b1;
		send_cmd(p, WORD_W'($urandom));
	endtask

	task automatic run_directed();
		logic [5:0] p;
		// no tape after reset: error already set
		send_frame(8'hff);                      // frame with no read is ignored
		send_tape_end();                        // tape end with no read too
		p = '0;
		p[PULSE_START_BIT] = 1'b1;
		send_cmd(p, '0);
		send_frame(8'h41);                      // missing tape ends the read
		p = '0;
		p[PULSE_SKIP_BIT] = 1'b1;
		send_cmd(p, '0);
		wait_idle();
		set_tape(1'b1);

		// alphanumeric read, full-scale accumulator
		p = '0;
		p[PULSE_START_BIT] = 1'b1;
		send_cmd(p, '1);
		send_frame(8'hff);
		p = '0;
		p[PULSE_SKIP_BIT] = 1'b1;
		p[PULSE_READ_BIT] = 1'b1;
		send_cmd(p, '0);
		p = '0;
		p[PULSE_SKIP_BIT] = 1'b1;
		send_cmd(p, '0);                        // done cleared by the read

		// binary read with an unmarked frame in between
		p = '0;
		p[PULSE_START_BIT] = 1'b1;
		p[PULSE_BIN_BIT] = 1'b1;
		send_cmd(p, '0);
		send_frame(8'h7f);
		send_frame(8'hbf);
		send_frame(8'h80);
		send_frame(8'haa);
		p = '0;
		p[PULSE_READ_BIT] = 1'b1;
		send_cmd(p, '0);

		// tape end in mid-read, then restarts during a read
		p = '0;
		p[PULSE_START_BIT] = 1'b1;
		p[PULSE_BIN_BIT] = 1'b1;
		send_cmd(p, '0);
		send_frame(8'hc1);
		send_tape_end();
		p = '0;
		p[PULSE_START_BIT] = 1'b1;
		send_cmd(p, '0);
		p[PULSE_BIN_BIT] = 1'b1;
		send_cmd(p, '0);

		// no-operation with every field at its top value
		send_word(make_word(FUNC_NOP, '1, '1, '1));
		// all command bits at once
		send_cmd('1, '0);
		send_frame(8'h00);
		send_tape_end();
		p = '0;
		p[PULSE_READ_BIT] = 1'b1;
		send_cmd(p, '1);
	endtask

	// start, frames with polls between them, then read the buffer back
	task automatic read_sequence();
		logic                bin;
		logic [5:0]          p;
		logic [FRAME_W-1:0]  fr;
		int                  marked;
		bin = 1'($urandom);
		if ($urandom_range(0, 3) == 0)
			send_poll();
		p = 6'($urandom);
		p[PULSE_START_BIT] = 1'b1;
		p[PULSE_BIN_BIT] = bin;
		send_cmd(p, WORD_W'($urandom));
		if (bin) begin
			marked = 0;
			while (marked < 3) begin
				fr = FRAME_W'($urandom);
				fr[BIN_MARK_BIT] = ($urandom_range(0, 3) != 0);
				if (fr[BIN_MARK_BIT])
					marked++;
				send_frame(fr);
				if ($urandom_range(0, 4) == 0)
					send_poll();
			end
		end else begin
			send_frame(FRAME_W'($urandom));
		end
		send_poll();
		p = 6'($urandom);
		p[PULSE_START_BIT] = 1'b0;
		p[PULSE_READ_BIT] = 1'b1;
		send_cmd(p, WORD_W'($urandom));
	endtask

	// read broken off by a tape end or a restart
	task automatic broken_sequence();
		logic [5:0] p;
		int         n;
		p = 6'($urandom);
		p[PULSE_START_BIT] = 1'b1;
		send_cmd(p, WORD_W'($urandom));
		n = $urandom_range(0, 2);
		repeat (n) send_frame(FRAME_W'($urandom));
		if ($urandom_range(0, 1) == 0) begin
			send_tape_end();
		end else begin
			p = 6'($urandom);
			p[PULSE_START_BIT] = 1'b1;
			send_cmd(p, WORD_W'($urandom));
		end
	endtask

	task automatic run_random_phase(input int n_items);
		int target;
		int pick;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				read_sequence();
			else if (pick < 9)
				send_word(make_word(2'($urandom), 6'($urandom), WORD_W'($urandom),
					FRAME_W'($urandom)));
			else
				broken_sequence();
		end
	endtask

	initial begin
		bit tape_plan[6];
		tape_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sb.reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// phases follow the tape plan; one in three runs without sender gaps
		for (int i = 0; i < 6; i++) begin
			wait_idle();
			set_tape(tape_plan[i]);
			sender_gaps = (i % 3 != 1);
			run_random_phase(ITEMS_PER_PHASE);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
